@@ rtl/rgbws_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbws_pkg
// Shared types, constants and arithmetic helpers for the RGB555 weighted
// blend and shade pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbws_pkg;

   localparam int unsigned CH_BITS  = 5;
   localparam int unsigned NUM_BITS = 12;
   localparam int unsigned DEN_BITS = 7;
   localparam int unsigned NUM_CH   = 3;
   localparam int unsigned PIX_BITS = 15;

   typedef logic [CH_BITS-1:0]  chan_type;
   typedef logic [NUM_BITS-1:0] num_type;
   typedef logic [DEN_BITS-1:0] den_type;
   typedef logic [PIX_BITS-1:0] pixel_type;

   localparam chan_type CH_MAX = 5'd31;
   localparam den_type  DEN_ONE = 7'd1;

   // Channel index 2 is red, 1 is green and 0 is blue.
   typedef struct packed {
      num_type   [NUM_CH-1:0] rem;
      chan_type  [NUM_CH-1:0] quot;
      den_type                den;
      pixel_type              shade;
   } div_state_type;

   // One restoring division step: quotient bit on top, new remainder below.
   function automatic logic [NUM_BITS:0] div_step(input num_type rem, input den_type den,
                                                  input logic [2:0] sh);
      num_type trial;
      trial = num_type'({5'd0, den}) << sh;
      if (rem >= trial) begin
         div_step = {1'b1, rem - trial};
      end else begin
         div_step = {1'b0, rem};
      end
   endfunction

   function automatic chan_type shade_ch(input chan_type s, input chan_type m);
      logic [9:0] prod;
      prod = {5'd0, s} * {5'd0, m};
      if (prod[9]) begin
         shade_ch = CH_MAX;
      end else begin
         shade_ch = prod[8:4];
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/rgbws_weight.sv @@
// ----------------------------------------------------------------------------
// rgbws_weight
// First stage: weighted channel sums and weight sum, or the bypass operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbws_weight (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        up_valid,
   output logic                       up_ready,
   input  wire  [15:0]                weight_pixel,
   input  wire  [15:0]                source_a,
   input  wire  [15:0]                source_b,
   input  wire  [15:0]                source_c,
   input  wire  [15:0]                shade_pixel,
   input  wire                        blend_enable,
   output logic                       dn_valid,
   input  wire                        dn_ready,
   output rgbws_pkg::div_state_type   dn_data
);

   logic                     valid_ff;
   rgbws_pkg::div_state_type data_ff;
   rgbws_pkg::div_state_type data_in;

   always_comb begin
      rgbws_pkg::chan_type wa;
      rgbws_pkg::chan_type wb;
      rgbws_pkg::chan_type wc;
      rgbws_pkg::den_type  wsum;
      wa   = weight_pixel[14:10];
      wb   = weight_pixel[9:5];
      wc   = weight_pixel[4:0];
      wsum = rgbws_pkg::den_type'(wa) + rgbws_pkg::den_type'(wb)
           + rgbws_pkg::den_type'(wc);
      data_in       = '0;
      data_in.shade = shade_pixel[14:0];
      for (int ch = 0; ch < 3; ch++) begin
         if (!blend_enable) begin
            data_in.rem[ch] = rgbws_pkg::num_type'(source_a[ch*5 +: 5]);
         end else if (wsum != '0) begin
            data_in.rem[ch] =
               rgbws_pkg::num_type'(wa) * rgbws_pkg::num_type'(source_a[ch*5 +: 5])
             + rgbws_pkg::num_type'(wb) * rgbws_pkg::num_type'(source_b[ch*5 +: 5])
             + rgbws_pkg::num_type'(wc) * rgbws_pkg::num_type'(source_c[ch*5 +: 5]);
         end
      end
      if (blend_enable && wsum != '0) begin
         data_in.den = wsum;
      end else begin
         data_in.den = rgbws_pkg::DEN_ONE;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/rgbws_divide.sv @@
// ----------------------------------------------------------------------------
// rgbws_divide
// Two register stages of restoring division: quotient bits 4 to 2, then 1 to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbws_divide (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        up_valid,
   output logic                       up_ready,
   input  rgbws_pkg::div_state_type   up_data,
   output logic                       dn_valid,
   input  wire                        dn_ready,
   output rgbws_pkg::div_state_type   dn_data
);

   logic                     hi_valid_ff;
   rgbws_pkg::div_state_type hi_data_ff;
   rgbws_pkg::div_state_type hi_data_in;
   logic                     hi_ready;
   logic                     lo_valid_ff;
   rgbws_pkg::div_state_type lo_data_ff;
   rgbws_pkg::div_state_type lo_data_in;

   always_comb begin
      logic [12:0] res;
      hi_data_in = up_data;
      for (int ch = 0; ch < 3; ch++) begin
         for (int st = 4; st >= 2; st--) begin
            res = rgbws_pkg::div_step(hi_data_in.rem[ch], hi_data_in.den, 3'(st));
            hi_data_in.rem[ch]      = res[11:0];
            hi_data_in.quot[ch][st] = res[12];
         end
      end
   end

   always_comb begin
      logic [12:0] res;
      lo_data_in = hi_data_ff;
      for (int ch = 0; ch < 3; ch++) begin
         for (int st = 1; st >= 0; st--) begin
            res = rgbws_pkg::div_step(lo_data_in.rem[ch], lo_data_in.den, 3'(st));
            lo_data_in.rem[ch]      = res[11:0];
            lo_data_in.quot[ch][st] = res[12];
         end
      end
   end

   assign hi_ready = !lo_valid_ff || dn_ready;
   assign up_ready = !hi_valid_ff || hi_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_valid_ff <= 1'b0;
         lo_valid_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            hi_valid_ff <= up_valid;
         end
         if (hi_ready) begin
            lo_valid_ff <= hi_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         hi_data_ff <= hi_data_in;
      end
      if (hi_ready && hi_valid_ff) begin
         lo_data_ff <= lo_data_in;
      end
   end

   assign dn_valid = lo_valid_ff;
   assign dn_data  = lo_data_ff;

endmodule

`default_nettype wire

@@ rtl/rgbws_shade.sv @@
// ----------------------------------------------------------------------------
// rgbws_shade
// Output stage: light modulation with saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbws_shade (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        up_valid,
   output logic                       up_ready,
   input  rgbws_pkg::div_state_type   up_data,
   output logic                       dn_valid,
   input  wire                        dn_ready,
   output rgbws_pkg::pixel_type       dn_pixel
);

   logic                 valid_ff;
   rgbws_pkg::pixel_type pixel_ff;
   rgbws_pkg::pixel_type pixel_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         pixel_in[ch*5 +: 5] = rgbws_pkg::shade_ch(up_data.shade[ch*5 +: 5],
                                                   up_data.quot[ch]);
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_pixel = pixel_ff;

endmodule

`default_nettype wire

@@ rtl/rgb555_weighted_blend_shade.sv @@
// ----------------------------------------------------------------------------
// rgb555_weighted_blend_shade
// Blends three RGB555 sources by a weight pixel and modulates the result with
// a shade pixel.
// ----------------------------------------------------------------------------
// The block accepts one word per cycle while req_ready is high, and each
// word passes through four register stages: weighted sums, two stages of
// restoring division of the channel sums by the weight sum, and the shade
// multiply into the output register. Each stage holds its word while the
// stage below is full, so a stalled output fills the pipeline before
// req_ready drops.
`default_nettype none

module rgb555_weighted_blend_shade (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [15:0]  req_weight_pixel,
   input  wire  [15:0]  req_source_a,
   input  wire  [15:0]  req_source_b,
   input  wire  [15:0]  req_source_c,
   input  wire  [15:0]  req_shade_pixel,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [14:0]  rsp_out_pixel,
   input  wire          csr_write_enable,
   input  wire          csr_write_data
);

   logic                     blend_enable_ff;
   logic                     wt_valid;
   logic                     wt_ready;
   rgbws_pkg::div_state_type wt_data;
   logic                     dv_valid;
   logic                     dv_ready;
   rgbws_pkg::div_state_type dv_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         blend_enable_ff <= csr_write_data;
      end
   end

   rgbws_weight u_weight (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .weight_pixel (req_weight_pixel),
      .source_a     (req_source_a),
      .source_b     (req_source_b),
      .source_c     (req_source_c),
      .shade_pixel  (req_shade_pixel),
      .blend_enable (blend_enable_ff),
      .dn_valid     (wt_valid),
      .dn_ready     (wt_ready),
      .dn_data      (wt_data)
   );

   rgbws_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .up_valid (wt_valid),
      .up_ready (wt_ready),
      .up_data  (wt_data),
      .dn_valid (dv_valid),
      .dn_ready (dv_ready),
      .dn_data  (dv_data)
   );

   rgbws_shade u_shade (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dv_valid),
      .up_ready (dv_ready),
      .up_data  (dv_data),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_pixel (rsp_out_pixel)
   );

   // The input stalls only when every stage is full and the output is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && wt_valid && dv_valid))
      else $error("input stalled while the pipeline had room");

   // A new result appears only from a word held in the last division stage.
   a_result_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dv_valid))
      else $error("result appeared without a word in the divider");

   // The pipeline is empty and ready right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> (req_ready && !rsp_valid && !wt_valid && !dv_valid))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
